// ----- rtl/core/polyev_pkg.sv -----
// shared types, codes and sizes of the polynomial evaluator
package polyev_pkg;

   // store sizing
   localparam int MAX_DEGREE  = 15;
   localparam int STORE_DEPTH = MAX_DEGREE + 1;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int DATA_W      = 32;

   // item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   // register index of the degree register
   localparam logic REG_DEGREE = 1'b0;

   // input transfer payload
   typedef struct packed {
      logic               func;
      logic [3:0]         coef_index;
      logic signed [31:0] coef_value;
      logic signed [31:0] x_point;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic signed [31:0] poly_value;
      logic               index_error;
   } rsp_type;

   // control from the sequencer to the multiply-add unit
   typedef struct packed {
      logic clear;
      logic step;
   } mac_ctrl_type;

endpackage

// ----- rtl/core/polyev_coef_store.sv -----
// coefficient memory with one write port and one registered read port
module polyev_coef_store (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [polyev_pkg::IDX_W-1:0]        wr_addr,
   input  logic [polyev_pkg::DATA_W-1:0]       wr_data,
   input  logic [polyev_pkg::IDX_W-1:0]        rd_addr,
   output logic [polyev_pkg::DATA_W-1:0]       rd_data
);

   logic [polyev_pkg::DATA_W-1:0] mem [polyev_pkg::STORE_DEPTH];
   logic [polyev_pkg::DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/polyev_mac.sv -----
// shared multiply-add unit holding the horner accumulator and the point
module polyev_mac (
   input  logic                          clock,
   input  polyev_pkg::mac_ctrl_type      ctrl,
   input  logic [polyev_pkg::DATA_W-1:0] x_value,
   input  logic [polyev_pkg::DATA_W-1:0] coef,
   output logic [polyev_pkg::DATA_W-1:0] acc
);

   logic [polyev_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic [polyev_pkg::DATA_W-1:0] x_ff, x_in;
   logic [polyev_pkg::DATA_W-1:0] product;

   // low half of the product, wraps modulo 2^32
   assign product = acc_ff * x_ff;

   // accumulator update
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      if (ctrl.clear) begin
         acc_in = '0;
         x_in   = x_value;
      end else if (ctrl.step) begin
         acc_in = product + coef;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
   end

   assign acc = acc_ff;

endmodule

// ----- rtl/core/polynomial_evaluator.sv -----
// top level: sequencer, degree register and result register of the evaluator
//
// Input channel req_*: one transfer carries func, coef_index, coef_value and
// x_point. A write (func 0) stores coef_value at coef_index, 0 being the
// highest-degree term; an index above the degree sets index_error and leaves
// the store alone. An evaluate (func 1) returns the wrapped 32-bit value of
// the polynomial at x_point by Horner's rule.
// Result channel rsp_*: exactly one transfer per accepted item, in order.
// Sequence: an evaluate runs one multiply-add per coefficient in the shared
// unit, paced by the registered read of the coefficient memory, and then
// loads the result register once it is free; a write goes straight to
// loading the result. The next item is taken after the result is loaded.
// req_stall is high while an item is in work. A stalled result holds in the
// result register; the next item's result waits in the unit until it leaves.
// The degree register sits at byte address 0 of the APB-style port.
// Reset (synchronous) clears degree and the handshake state; coefficients are
// undefined until written.
module polynomial_evaluator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  polyev_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output polyev_pkg::rsp_type rsp_payload,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_type;

   state_type                        state_ff, state_in;
   logic [polyev_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic                             err_ff, err_in;
   logic [3:0]                       degree_ff, degree_in;
   logic [polyev_pkg::IDX_W-1:0]     eff_degree;
   logic                             rsp_valid_ff, rsp_valid_in;
   polyev_pkg::rsp_type              rsp_payload_ff, rsp_payload_in;

   logic                             req_take;
   logic                             bad_index;
   logic                             wr_en;
   logic [polyev_pkg::IDX_W-1:0]     rd_addr;
   logic [polyev_pkg::DATA_W-1:0]    rd_data;
   logic [polyev_pkg::DATA_W-1:0]    acc;
   polyev_pkg::mac_ctrl_type         mac_ctrl;
   logic                             out_free;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == polyev_pkg::REG_DEGREE) ? {28'd0, degree_ff} : 32'd0;

   always_comb begin
      degree_in = degree_ff;
      if (psel && penable && pwrite && (paddr[2] == polyev_pkg::REG_DEGREE)) begin
         degree_in = pwdata[3:0];
      end
   end

   // degree saturates at MAX_DEGREE, the top index of the store
   assign eff_degree = (32'(degree_ff) > polyev_pkg::MAX_DEGREE)
                       ? polyev_pkg::IDX_W'(polyev_pkg::MAX_DEGREE)
                       : polyev_pkg::IDX_W'(degree_ff);

   // input transfer and write decode
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign bad_index = (32'(req_payload.coef_index) > 32'(eff_degree));
   assign wr_en     = req_take && (req_payload.func == polyev_pkg::FUNC_WRITE) && !bad_index;

   // read one coefficient ahead of the multiply-add
   assign rd_addr = (state_ff == ST_RUN) ? idx_ff + 1'b1 : '0;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mac_ctrl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mac_ctrl.clear = 1'b1;
               idx_in         = '0;
               if (req_payload.func == polyev_pkg::FUNC_EVAL) begin
                  err_in   = 1'b0;
                  state_in = ST_RUN;
               end else begin
                  err_in   = bad_index;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_RUN: begin
            mac_ctrl.step = 1'b1;
            if (idx_ff == eff_degree) begin
               state_in = ST_HOLD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.poly_value  = acc;
               rsp_payload_in.index_error = err_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         degree_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         degree_ff    <= degree_in;
      end
      idx_ff         <= idx_in;
      err_ff         <= err_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // coefficient memory
   polyev_coef_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (polyev_pkg::IDX_W'(req_payload.coef_index)),
      .wr_data (req_payload.coef_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared multiply-add unit
   polyev_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .x_value (req_payload.x_point),
      .coef    (rd_data),
      .acc     (acc)
   );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for the polynomial evaluator: scoreboard, bus drivers and stimulus
module tb_top;

   // coefficient patterns for the directed part: sign extremes, zero, one, stripes
   localparam logic [31:0] EDGE_COEFS [polyev_pkg::STORE_DEPTH] = '{
      32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
      32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0003,
      32'hffff_fffd, 32'h1234_5678, 32'hfedc_ba98, 32'h0001_0000,
      32'h8000_0001, 32'h7fff_fffe, 32'h0f0f_0f0f, 32'hf0f0_f0f0
   };

   // expected results of the evaluator, with its own copy of store and degree
   class poly_scoreboard;
      logic [31:0]                       coef_store [polyev_pkg::STORE_DEPTH];
      logic [polyev_pkg::STORE_DEPTH-1:0] coef_written;
      logic [3:0]                        degree;
      polyev_pkg::rsp_type               expected_q [$];
      int                                mismatches;
      int                                results_seen;
      int                                writes;
      int                                evals;
      int                                index_errors;

      function new();
         coef_written = '0;
         degree       = '0;
         mismatches   = 0;
         results_seen = 0;
         writes       = 0;
         evals        = 0;
         index_errors = 0;
      endfunction

      function void set_degree(logic [3:0] d);
         degree = d;
      endfunction

      // every coefficient in use must have been written since reset
      function bit eval_allowed();
         for (int i = 0; i <= degree; i++)
            if (!coef_written[i])
               return 1'b0;
         return 1'b1;
      endfunction

      // horner's rule, every product and sum wrapping to 32 bits
      function logic [31:0] horner_value(logic [31:0] x);
         logic [31:0] acc;
         acc = '0;
         for (int i = 0; i <= degree; i++)
            acc = acc * x + coef_store[i];
         return acc;
      endfunction

      // one accepted input transfer: update the store and queue the result
      function void note_request(polyev_pkg::req_type r);
         polyev_pkg::rsp_type exp_rsp;
         exp_rsp = '0;
         if (r.func == polyev_pkg::FUNC_EVAL) begin
            evals++;
            exp_rsp.poly_value = horner_value(r.x_point);
         end else begin
            writes++;
            if (r.coef_index > degree) begin
               index_errors++;
               exp_rsp.index_error = 1'b1;
            end else begin
               coef_store[r.coef_index]   = r.coef_value;
               coef_written[r.coef_index] = 1'b1;
            end
         end
         expected_q.push_back(exp_rsp);
      endfunction

      // one accepted result transfer against the oldest expectation
      function void check_result(polyev_pkg::rsp_type got);
         polyev_pkg::rsp_type exp_rsp;
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with nothing expected: poly_value %h index_error %b",
                        results_seen, got.poly_value, got.index_error);
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (got.poly_value !== exp_rsp.poly_value || got.index_error !== exp_rsp.index_error)
         begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d mismatch: poly_value exp %h got %h, index_error exp %b got %b",
                        results_seen, exp_rsp.poly_value, got.poly_value,
                        exp_rsp.index_error, got.index_error);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   polyev_pkg::req_type req_payload;
   logic                rsp_valid;
   logic                rsp_stall;
   polyev_pkg::rsp_type rsp_payload;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [2:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   poly_scoreboard sb = new();
   bit             pressure_pending = 1'b0;
   int             long_holds       = 0;
   int             degree_settings  = 0;

   polynomial_evaluator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // present one item from the falling edge until the transfer happens
   task automatic send_item(polyev_pkg::req_type r);
      @(negedge clock);
      req_valid   = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   // drop valid for a number of cycles
   task automatic sender_idle(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // none when bursty; else mostly back to back, sometimes a short gap, rarely a long pause
   function automatic int sender_gap(bit bursty);
      int r;
      if (bursty)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // wait until every result is back and the block has settled
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   // setup and access cycle on the register port
   task automatic csr_write(logic [3:0] d);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {polyev_pkg::REG_DEGREE, 2'b00};
      pwdata  = 32'(d);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_degree(d);
      degree_settings++;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   function automatic polyev_pkg::req_type make_req(logic func, logic [3:0] idx,
                                                    logic [31:0] cval, logic [31:0] xp);
      polyev_pkg::req_type r;
      r.func       = func;
      r.coef_index = idx;
      r.coef_value = cval;
      r.x_point    = xp;
      return r;
   endfunction

   // data word leaning toward the sign extremes and small values
   function automatic logic [31:0] rand_word();
      unique case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2, 3:    return 32'($signed($urandom_range(0, 8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   // random item; evaluates only once the used coefficients are all written
   function automatic polyev_pkg::req_type random_req();
      polyev_pkg::req_type r;
      r.func = $urandom_range(0, 1) ? polyev_pkg::FUNC_EVAL : polyev_pkg::FUNC_WRITE;
      if (r.func == polyev_pkg::FUNC_EVAL && !sb.eval_allowed())
         r.func = polyev_pkg::FUNC_WRITE;
      if ($urandom_range(0, 6) == 0)
         r.coef_index = 4'($urandom_range(0, 15));
      else
         r.coef_index = 4'($urandom_range(0, sb.degree));
      r.coef_value = rand_word();
      r.x_point    = rand_word();
      return r;
   endfunction

   // result side: checks transfers and stalls at random
   initial begin
      int hold;
      int mode_left;
      int r;
      bit quiet;
      rsp_stall = 1'b0;
      hold      = 0;
      mode_left = 100;
      quiet     = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_payload);
         @(negedge clock);
         // switch between stretches with and without stalls
         mode_left--;
         if (mode_left <= 0) begin
            quiet     = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 300);
         end
         // one long hold-off while the sender keeps offering
         if (pressure_pending && sb.pending() != 0) begin
            pressure_pending = 1'b0;
            hold             = 120;
            long_holds++;
         end
         if (hold > 0) begin
            rsp_stall = 1'b1;
            hold--;
         end else if (quiet) begin
            rsp_stall = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_stall = 1'b0;
            end else begin
               rsp_stall = 1'b1;
               hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [3:0] d;
      bit         bursty;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // degree 0 after reset: only index 0 is in range
      send_item(make_req(polyev_pkg::FUNC_WRITE, 4'd0, 32'h7fff_ffff, 32'h0));
      send_item(make_req(polyev_pkg::FUNC_WRITE, 4'd15, 32'hffff_ffff, 32'hffff_ffff));
      sender_idle(sender_gap(1'b0));
      send_item(make_req(polyev_pkg::FUNC_WRITE, 4'd1, 32'h0000_0005, 32'h0));
      send_item(make_req(polyev_pkg::FUNC_EVAL, 4'd15, 32'hffff_ffff, 32'h0000_0005));
      wait_idle();

      // full degree: fill the whole store, then evaluate at the extreme points
      csr_write(4'd15);
      for (int i = 0; i < polyev_pkg::STORE_DEPTH; i++) begin
         send_item(make_req(polyev_pkg::FUNC_WRITE, 4'(i), EDGE_COEFS[i], $urandom));
         sender_idle(sender_gap(1'b0));
      end
      send_item(make_req(polyev_pkg::FUNC_EVAL, 4'd0, 32'h0, 32'h0000_0000));
      send_item(make_req(polyev_pkg::FUNC_EVAL, 4'd0, 32'h0, 32'h0000_0001));
      send_item(make_req(polyev_pkg::FUNC_EVAL, 4'd0, 32'h0, 32'hffff_ffff));
      send_item(make_req(polyev_pkg::FUNC_EVAL, 4'd0, 32'h0, 32'h8000_0000));
      send_item(make_req(polyev_pkg::FUNC_EVAL, 4'd0, 32'h0, 32'h7fff_ffff));
      send_item(make_req(polyev_pkg::FUNC_EVAL, 4'd0, 32'h0, 32'h0000_0002));

      // random phases over several degrees, the extremes among them
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         unique case (p)
            0, 4:    d = 4'd15;
            1:       d = 4'd0;
            2:       d = 4'd1;
            5:       d = 4'd7;
            default: d = 4'($urandom_range(0, 15));
         endcase
         csr_write(d);
         bursty = (p % 3 == 1);
         if (p == 3) begin
            bursty           = 1'b1;
            pressure_pending = 1'b1;
         end
         for (int n = 0; n < 125; n++) begin
            send_item(random_req());
            sender_idle(sender_gap(bursty));
         end
      end

      wait_idle();
      repeat (30) @(posedge clock);
      $display("covered %0d coefficient writes (%0d out of range) and %0d evaluations",
               sb.writes, sb.index_errors, sb.evals);
      $display("over %0d degree settings, with %0d long result hold-off(s), %0d results checked",
               degree_settings, long_holds, sb.results_seen);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #20_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
